// ----- sv/kmcd_pkg.sv -----
package kmcd_pkg;

    localparam int ROWS        = 8;
    localparam int COLUMNS     = 4;
    localparam int LIGHTS      = 23;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int KEY_W       = ROW_W + COL_W;
    localparam int LIGHT_IDX_W = 5;

    // input and output stream payload widths, padded to whole bytes
    localparam int S_DATA_W = ((COL_W + ROWS + 7) / 8) * 8;
    localparam int M_FIELD_W = KEY_W + 1 + 1 + LIGHT_IDX_W + LIGHTS;
    localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // key numbers bounding the ranges of the indicator map
    localparam logic [KEY_W-1:0]       KEY_FIRST_LIT  = KEY_W'(16);
    localparam logic [KEY_W-1:0]       KEY_LOW_A_END  = KEY_W'(18);
    localparam logic [KEY_W-1:0]       KEY_LOW_B_END  = KEY_W'(23);
    localparam logic [KEY_W-1:0]       KEY_HIGH_A_END = KEY_W'(26);
    localparam logic [LIGHT_IDX_W-1:0] MAP_MIRROR     = LIGHT_IDX_W'(26);
    localparam logic [LIGHT_IDX_W-1:0] MAP_OFFSET_LOW = LIGHT_IDX_W'(8);
    localparam logic [LIGHT_IDX_W-1:0] MAP_OFFSET_HI  = LIGHT_IDX_W'(24);

    typedef struct packed {
        logic                   has_light;
        logic [LIGHT_IDX_W-1:0] light_index;
    } t_light;

    typedef struct packed {
        logic                   has_light;
        logic [LIGHT_IDX_W-1:0] light_index;
        logic [LIGHTS-1:0]      light_next;
    } t_event;

    function automatic t_light light_of_key(input logic [KEY_W-1:0] key);
        t_light res;
        res = '0;
        if (key >= KEY_FIRST_LIT) begin
            res.has_light = 1'b1;
            if (key <= KEY_LOW_A_END) begin
                res.light_index = MAP_MIRROR - LIGHT_IDX_W'(key);
            end else if (key <= KEY_LOW_B_END) begin
                res.light_index = LIGHT_IDX_W'(key) - MAP_OFFSET_LOW;
            end else if (key <= KEY_HIGH_A_END) begin
                res.light_index = MAP_MIRROR - LIGHT_IDX_W'(key);
            end else begin
                res.light_index = LIGHT_IDX_W'(key) - MAP_OFFSET_HI;
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/kmcd_event_unit.sv -----
module kmcd_event_unit (
    input  logic [kmcd_pkg::KEY_W-1:0]  i_key,
    input  logic                        i_released,
    input  logic [kmcd_pkg::LIGHTS-1:0] i_lights,
    output kmcd_pkg::t_event            o_event
);
    import kmcd_pkg::*;

    t_light            w_map;
    logic              w_in_range;
    logic [LIGHTS-1:0] w_bit;

    always_comb begin
        w_map      = light_of_key(i_key);
        w_in_range = w_map.has_light && (32'(w_map.light_index) < 32'(LIGHTS));
        w_bit      = LIGHTS'(1) << w_map.light_index;

        o_event.has_light   = w_map.has_light;
        o_event.light_index = w_map.light_index;
        o_event.light_next  = i_lights;
        if (w_in_range) begin
            // press lights the indicator, release clears it
            if (i_released) begin
                o_event.light_next = i_lights & ~w_bit;
            end else begin
                o_event.light_next = i_lights | w_bit;
            end
        end
    end

endmodule

// ----- sv/key_matrix_change_detector.sv -----
// Key matrix change detector.
// Input stream: one transaction per scanned column, tdata = {row_levels, column}
// (row bit 1 = released). The block compares the levels with the stored levels
// of that column and emits one output transaction per changed row, lowest row
// first: key number, released flag, mapped indicator and the light vector after
// that event; tlast marks the final event of the column. A report without any
// change produces no output transaction.
// Throughput: rows are visited by one event unit, one row per cycle while the
// output is not stalled, from row 0 up to the highest changed row of the column.
// s_tready is high only between column reports, so the next column is taken only
// after the scan of the last one is through. An input transaction is stored in the
// scan registers, and each event built from them is then held in the output register.
// The output register holds a finished event while the receiver stalls; the scan
// waits on a changed row until that register is free, then carries on.
// Reset: all keys read as released, all lights off, no output pending.
module key_matrix_change_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [1:0] column, [9:2] row_levels, rest zero
    input  logic [kmcd_pkg::S_DATA_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [4:0] key_number, [5] released, [6] has_light, [11:7] light_index,
    // [34:12] light_vector, rest zero
    output logic [kmcd_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast
);
    import kmcd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                r_state, n_state;
    logic [ROWS-1:0]     r_levels [COLUMNS];
    logic [LIGHTS-1:0]   r_lights, n_lights;
    logic [ROWS-1:0]     r_diff, n_diff;
    logic [ROWS-1:0]     r_now, n_now;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic                r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;
    logic                r_out_last, n_out_last;

    logic [COL_W-1:0]    w_in_col;
    logic [ROWS-1:0]     w_in_levels;
    logic [ROWS-1:0]     w_in_diff;
    logic                w_accept;
    logic [ROWS-1:0]     w_row_bit;
    logic [ROWS-1:0]     w_rest;
    logic                w_cur;
    logic                w_out_free;
    logic                w_emit;
    t_event              w_event;

    assign w_in_col    = i_s_tdata[COL_W-1:0];
    assign w_in_levels = i_s_tdata[COL_W +: ROWS];
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_in_diff   = r_levels[w_in_col] ^ w_in_levels;

    assign w_row_bit  = ROWS'(1) << r_row;
    assign w_rest     = r_diff & ~w_row_bit;
    assign w_cur      = r_diff[r_row];
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_emit     = (r_state == ST_SCAN) && w_cur && w_out_free;

    kmcd_event_unit u_event (
        .i_key      ({r_col, r_row}),
        .i_released (r_now[r_row]),
        .i_lights   (r_lights),
        .o_event    (w_event)
    );

    always_comb begin
        n_state     = r_state;
        n_lights    = r_lights;
        n_diff      = r_diff;
        n_now       = r_now;
        n_col       = r_col;
        n_row       = r_row;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_diff  = w_in_diff;
                    n_now   = w_in_levels;
                    n_col   = w_in_col;
                    n_row   = '0;
                    n_state = (w_in_diff != '0) ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN: begin
                // unchanged rows are skipped; a changed row waits for the output
                if (!w_cur || w_emit) begin
                    n_diff = w_rest;
                    n_row  = r_row + ROW_W'(1);
                    if (w_rest == '0) begin
                        n_state = ST_IDLE;
                    end
                end
                if (w_emit) begin
                    n_lights    = w_event.light_next;
                    n_out_valid = 1'b1;
                    n_out_last  = (w_rest == '0);
                    n_out_data  = M_DATA_W'({w_event.light_next, w_event.light_index,
                                             w_event.has_light, r_now[r_row],
                                             r_col, r_row});
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lights    <= '0;
            r_row       <= '0;
            r_diff      <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < COLUMNS; c++) begin
                r_levels[c] <= '1;
            end
        end else begin
            r_state     <= n_state;
            r_lights    <= n_lights;
            r_row       <= n_row;
            r_diff      <= n_diff;
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_levels[w_in_col] <= w_in_levels;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_col      <= n_col;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // a scan always has a changed row left to report
    a_scan_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_diff != '0))
        else $error("scan active with no changed rows left");

    // rows below the scan position have all been reported
    a_rows_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_diff & (w_row_bit - ROWS'(1))) == '0))
        else $error("changed row skipped by the scan");

    // the pending event carries the current light state
    a_light_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[KEY_W + 2 + LIGHT_IDX_W +: LIGHTS] == r_lights))
        else $error("light vector out of step with light state");

    // a key without an indicator reports index zero
    a_no_light_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[KEY_W + 1]) |->
            (o_m_tdata[KEY_W + 2 +: LIGHT_IDX_W] == '0))
        else $error("light index set for a key without indicator");
`endif

endmodule
